// ===== rtl/ntct_pkg.sv =====
// Shared types and calibration constants for the NTC code to temperature unit.
`timescale 1ns / 1ps

package ntct_pkg;

  localparam int unsigned SEG_N      = 12;
  localparam int unsigned CODE_W     = 10;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned DIST_W     = 8;   // largest segment span is 221 codes
  localparam int unsigned SLOPE_W    = 10;
  localparam int unsigned PROD_W     = 15;  // largest distance times slope is 20020
  localparam int unsigned TERM_W     = 8;   // largest segment term is 200
  localparam int unsigned SEG_IDX_W  = 4;

  // Reciprocal of 100: (x * 5243) >> 19 is exact for x below 43699
  localparam int unsigned RECIP_100  = 5243;
  localparam int unsigned RECIP_SH   = 19;
  localparam int unsigned RECIP_W    = 13;

  // Register map
  localparam logic REG_CODE_MIN = 1'b0;
  localparam logic REG_CODE_MAX = 1'b1;

  localparam logic [CODE_W-1:0] CODE_MIN_RST = 10'd39;
  localparam logic [CODE_W-1:0] CODE_MAX_RST = 10'd858;

  // How the segment term is formed from the distance
  typedef enum logic [1:0] {
    KIND_DIV,  // floor(d * slope / 100)
    KIND_MUL,  // d * slope, integer slope
    KIND_TAB   // rounded table for the second warmest segment
  } seg_kind_e;

  typedef logic [CODE_W-1:0] code_t;

  // Segment bounds, inclusive, warmest segment last
  localparam code_t SEG_LO [SEG_N] = '{
    10'd779, 10'd679, 10'd458, 10'd357, 10'd271, 10'd204,
    10'd152, 10'd114, 10'd86,  10'd66,  10'd49,  10'd39
  };
  localparam code_t SEG_HI [SEG_N] = '{
    10'd858, 10'd778, 10'd678, 10'd457, 10'd356, 10'd270,
    10'd203, 10'd151, 10'd113, 10'd85,  10'd65,  10'd48
  };
  // Distance is measured down from this anchor
  localparam code_t SEG_ANCHOR [SEG_N] = '{
    10'd858, 10'd778, 10'd678, 10'd457, 10'd356, 10'd270,
    10'd203, 10'd151, 10'd113, 10'd85,  10'd65,  10'd49
  };
  localparam logic signed [TEMP_W-1:0] SEG_BASE [SEG_N] = '{
    -12'sd92,  12'sd8,   12'sd104, 12'sd300, 12'sd400, 12'sd495,
     12'sd590, 12'sd685, 12'sd780, 12'sd880, 12'sd980, 12'sd1080
  };
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_N] = '{
    10'd125, 10'd1,   10'd91,  10'd1,   10'd116, 10'd159,
    10'd192, 10'd263, 10'd357, 10'd5,   10'd0,   10'd10
  };
  localparam seg_kind_e SEG_KIND [SEG_N] = '{
    KIND_DIV, KIND_MUL, KIND_DIV, KIND_MUL, KIND_DIV, KIND_DIV,
    KIND_DIV, KIND_DIV, KIND_DIV, KIND_MUL, KIND_TAB, KIND_MUL
  };

  // Second warmest segment: floor(d * 6.5), plus ten when its last digit is 5 or more
  function automatic logic [TERM_W-1:0] tab_term(input logic [4:0] d);
    logic [TERM_W-1:0] r;
    case (d)
      5'd0:    r = 8'd0;
      5'd1:    r = 8'd16;
      5'd2:    r = 8'd13;
      5'd3:    r = 8'd29;
      5'd4:    r = 8'd36;
      5'd5:    r = 8'd32;
      5'd6:    r = 8'd49;
      5'd7:    r = 8'd55;
      5'd8:    r = 8'd52;
      5'd9:    r = 8'd68;
      5'd10:   r = 8'd75;
      5'd11:   r = 8'd71;
      5'd12:   r = 8'd88;
      5'd13:   r = 8'd84;
      5'd14:   r = 8'd91;
      5'd15:   r = 8'd107;
      5'd16:   r = 8'd104;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Contents of the first pipeline register
  typedef struct packed {
    logic                      ok;
    logic                      div;
    logic signed [TEMP_W-1:0]  base;
    logic [PROD_W-1:0]         prod;
  } stage_a_t;

endpackage

// ===== rtl/ntc_adc_to_temperature_unit.sv =====
// NTC converter code to temperature in tenths of a degree, piecewise-linear.
// An accepted beat passes the first pipeline register, then the output register.
// Throughput: one beat per cycle unless the output stalls; the slope multiply and
//   divide by 100 (reciprocal multiply) sit in separate stages, one multiply each.
// Reset: rst_ni low clears both pipeline valid bits and loads code_min = 39,
//   code_max = 858; no clearing pass is needed.
`timescale 1ns / 1ps

module ntc_adc_to_temperature_unit
  import ntct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [9:0] adc_code, [15:10] zero
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] temp_tenths, [15:12] zero
  output logic        m_axis_tuser_o,   // [0] out_of_range
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  code_t code_min_q, code_max_q;

  logic     a_valid_q;
  stage_a_t a_q, a_d;
  logic     b_valid_q;
  logic signed [TEMP_W-1:0] temp_q, temp_d;
  logic     oor_q;

  logic adv_b, adv_a;
  logic cfg_wr;

  code_t                   code;
  logic                    hit;
  logic [SEG_IDX_W-1:0]    seg;
  logic [CODE_W-1:0]       dist_full;
  logic [DIST_W-1:0]       seg_dist;
  logic [17:0]             slope_prod;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [TERM_W-1:0]       term;

  // Pipeline flow control
  assign adv_b = !b_valid_q || m_axis_tready_i;
  assign adv_a = !a_valid_q || adv_b;
  assign s_axis_tready_o = adv_a;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_min_q <= CODE_MIN_RST;
      code_max_q <= CODE_MAX_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CODE_MIN: code_min_q <= pwdata[CODE_W-1:0];
        REG_CODE_MAX: code_max_q <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CODE_MIN: prdata = {22'b0, code_min_q};
      REG_CODE_MAX: prdata = {22'b0, code_max_q};
      default:      prdata = '0;
    endcase
  end

  // Segment decode and slope product
  assign code = s_axis_tdata_i[CODE_W-1:0];

  always_comb begin
    hit = 1'b0;
    seg = '0;
    for (int i = 0; i < SEG_N; i++) begin
      if (code >= SEG_LO[i] && code <= SEG_HI[i]) begin
        hit = 1'b1;
        seg = SEG_IDX_W'(i);
      end
    end
  end

  assign dist_full  = SEG_ANCHOR[seg] - code;
  assign seg_dist   = dist_full[DIST_W-1:0];
  assign slope_prod = {10'b0, seg_dist} * {8'b0, SEG_SLOPE[seg]};

  always_comb begin
    a_d.ok   = hit && (code >= code_min_q) && (code <= code_max_q);
    a_d.div  = (SEG_KIND[seg] == KIND_DIV);
    a_d.base = SEG_BASE[seg];
    case (SEG_KIND[seg])
      KIND_TAB: a_d.prod = {7'b0, tab_term(seg_dist[4:0])};
      default:  a_d.prod = slope_prod[PROD_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_a) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && s_axis_tvalid_i) begin
      a_q <= a_d;
    end
  end

  // Divide by 100 through the reciprocal for KIND_DIV segments, add the segment base
  assign recip_prod = {{RECIP_W{1'b0}}, a_q.prod} * (PROD_W+RECIP_W)'(RECIP_100);
  assign term = a_q.div ? recip_prod[RECIP_SH +: TERM_W] : a_q.prod[TERM_W-1:0];
  assign temp_d = a_q.ok ? (a_q.base + $signed({4'b0, term})) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b && a_valid_q) begin
      temp_q <= temp_d;
      oor_q  <= !a_q.ok;
    end
  end

  assign m_axis_tvalid_o = b_valid_q;
  assign m_axis_tdata_o  = {4'b0, temp_q};
  assign m_axis_tuser_o  = oor_q;

  // Checks
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 16'd0))
    else $error("out-of-range beat carries a nonzero temperature");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (temp_q >= -12'sd100 && temp_q <= 12'sd1200))
    else $error("temperature outside the calibrated span");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output register is empty");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_valid_q) |=> b_valid_q)
    else $error("first stage beat did not advance into an empty output stage");

endmodule
